/* sv/assert_macros.svh */
// Assertion macros shared by the spectral flux beat detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define SFBD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SFBD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* sv/sfbd_pkg.sv */
// Shared constants and types of the spectral flux beat detector.
package sfbd_pkg;

   localparam int BINS = 512;
   localparam int MAG_W = 16;
   localparam int THR_W = 16;
   localparam int HOLD_W = 8;
   localparam int IDX_W = $clog2(BINS);
   localparam int FILL_W = IDX_W + 1;
   localparam int SUM_W = MAG_W + $clog2(BINS);
   localparam int MEAN_SHIFT = $clog2(BINS + 1) - 1;

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(BINS - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BINS);
   localparam logic [SUM_W-1:0] MEAN_MAX = {{(SUM_W - MAG_W){1'b0}}, {MAG_W{1'b1}}};

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLUX_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF_FRAMES = 1'd1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd77;
   localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 8'd10;

   typedef struct packed {
      logic beat;
      logic [MAG_W-1:0] flux_mean;
   } sfbd_result_type;

endpackage

/* sv/sfbd_interfaces.sv */
// Handshake interfaces for the bin input channel and the result channel.
interface sfbd_req_if;
   logic valid;
   logic ready;
   logic [sfbd_pkg::MAG_W-1:0] magnitude;
   logic last_bin;

   modport source (output valid, output magnitude, output last_bin, input ready);
   modport sink (input valid, input magnitude, input last_bin, output ready);
endinterface

interface sfbd_rsp_if;
   logic valid;
   logic ready;
   logic beat;
   logic [sfbd_pkg::MAG_W-1:0] flux_mean;

   modport source (output valid, output beat, output flux_mean, input ready);
   modport sink (input valid, input beat, input flux_mean, output ready);
endinterface

/* sv/sfbd_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module sfbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] storage [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         storage[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= storage[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

/* sv/sfbd_flux.sv */
// Flux datapath: previous-frame memory, positive difference sum and beat decision.
`include "assert_macros.svh"

module sfbd_flux (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [sfbd_pkg::MAG_W-1:0]      magnitude,
   input  logic                            last_bin,
   input  logic [sfbd_pkg::THR_W-1:0]      flux_threshold,
   input  logic [sfbd_pkg::HOLD_W-1:0]     holdoff_frames,
   output logic                            pending,
   output logic                            result_push,
   output sfbd_pkg::sfbd_result_type       result
);

   logic [sfbd_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [sfbd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic                        frame_end;

   logic                        s1_valid_ff;
   logic [sfbd_pkg::MAG_W-1:0]  s1_mag_ff;
   logic [sfbd_pkg::IDX_W-1:0]  s1_idx_ff;
   logic                        s1_end_ff;
   logic                        s1_hit_ff;
   logic                        s1_fwd_ff;
   logic [sfbd_pkg::MAG_W-1:0]  s1_fwd_data_ff;

   logic [sfbd_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [sfbd_pkg::HOLD_W-1:0] holdoff_ff, holdoff_in;

   logic [sfbd_pkg::MAG_W-1:0]  ram_read_data;
   logic [sfbd_pkg::MAG_W-1:0]  prev_mag;
   logic [sfbd_pkg::MAG_W-1:0]  diff;
   logic [sfbd_pkg::SUM_W-1:0]  sum_total;
   logic [sfbd_pkg::SUM_W-1:0]  mean_full;
   logic [sfbd_pkg::MAG_W-1:0]  mean;
   logic [sfbd_pkg::HOLD_W-1:0] holdoff_dec;
   logic                        beat;

   sfbd_ram #(
      .WIDTH (sfbd_pkg::MAG_W),
      .DEPTH (sfbd_pkg::BINS)
   ) u_prev_ram (
      .clock         (clock),
      .write_enable  (s1_valid_ff),
      .write_address (s1_idx_ff),
      .write_data    (s1_mag_ff),
      .read_enable   (accept),
      .read_address  (idx_ff),
      .read_data     (ram_read_data)
   );

   // Entries at or beyond the fill mark were never written and read as zero.
   always_comb begin
      frame_end = last_bin || (idx_ff == sfbd_pkg::LAST_INDEX);
      idx_in = idx_ff;
      if (accept) begin
         idx_in = frame_end ? '0 : idx_ff + 1'b1;
      end
      fill_in = fill_ff;
      if (s1_valid_ff && ({1'b0, s1_idx_ff} == fill_ff)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_comb begin
      if (s1_fwd_ff) begin
         prev_mag = s1_fwd_data_ff;
      end else if (s1_hit_ff) begin
         prev_mag = ram_read_data;
      end else begin
         prev_mag = '0;
      end
      diff = (s1_mag_ff > prev_mag) ? s1_mag_ff - prev_mag : '0;
      sum_total = sum_ff + sfbd_pkg::SUM_W'(diff);
      mean_full = sum_total >> sfbd_pkg::MEAN_SHIFT;
      mean = (mean_full > sfbd_pkg::MEAN_MAX) ? {sfbd_pkg::MAG_W{1'b1}}
                                              : mean_full[sfbd_pkg::MAG_W-1:0];
      holdoff_dec = (holdoff_ff != '0) ? holdoff_ff - 1'b1 : '0;
      beat = (mean > flux_threshold) && (holdoff_dec == '0);

      sum_in = sum_ff;
      holdoff_in = holdoff_ff;
      if (s1_valid_ff) begin
         if (s1_end_ff) begin
            sum_in = '0;
            holdoff_in = beat ? holdoff_frames : holdoff_dec;
         end else begin
            sum_in = sum_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         fill_ff <= '0;
         s1_valid_ff <= 1'b0;
         sum_ff <= '0;
         holdoff_ff <= sfbd_pkg::HOLDOFF_RESET;
      end else begin
         idx_ff <= idx_in;
         fill_ff <= fill_in;
         s1_valid_ff <= accept;
         sum_ff <= sum_in;
         holdoff_ff <= holdoff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mag_ff <= magnitude;
         s1_idx_ff <= idx_ff;
         s1_end_ff <= frame_end;
         s1_hit_ff <= {1'b0, idx_ff} < fill_ff;
         s1_fwd_ff <= s1_valid_ff && (s1_idx_ff == idx_ff);
         s1_fwd_data_ff <= s1_mag_ff;
      end
   end

   assign pending = s1_valid_ff && s1_end_ff;
   assign result_push = s1_valid_ff && s1_end_ff;
   assign result.beat = beat;
   assign result.flux_mean = mean;

   `SFBD_ASSERT(a_fill_bounded, fill_ff <= sfbd_pkg::FILL_MAX, "Fill mark beyond bin count.")
   `SFBD_ASSERT(a_write_in_prefix, s1_valid_ff |-> ({1'b0, s1_idx_ff} <= fill_ff), "Write skips an unwritten bin.")
   `SFBD_ASSERT(a_frame_restart, (s1_valid_ff && s1_end_ff) |=> (idx_ff == '0 || s1_idx_ff == '0), "Frame did not restart at bin zero.")

endmodule

/* sv/sfbd_out_fifo.sv */
// Two-word result queue that drives the result channel.
`include "assert_macros.svh"

module sfbd_out_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sfbd_pkg::sfbd_result_type  push_data,
   output logic [1:0]                 count,
   sfbd_rsp_if.source                 rsp_if
);

   sfbd_pkg::sfbd_result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop = rsp_if.valid && rsp_if.ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count = count_ff;
   assign rsp_if.valid = count_ff != 2'd0;
   assign rsp_if.beat = entry_ff[rd_ptr_ff].beat;
   assign rsp_if.flux_mean = entry_ff[rd_ptr_ff].flux_mean;

   `SFBD_ASSERT(a_no_overflow, !(push && !pop && count_ff == 2'd2), "Result word pushed into a full queue.")
   `SFBD_ASSERT(a_count_bounded, count_ff <= 2'd2, "Result queue count out of range.")

endmodule

/* sv/spectral_flux_beat_detector_unit.sv */
// Top level of the spectral flux beat detector.
//
//   Channel   Direction  Word
//   req_if    in         magnitude[15:0], last_bin: one FFT bin
//   rsp_if    out        beat, flux_mean[15:0]: one word per completed frame
//   csr_*     in         write enable, index, data: threshold and hold-off
//
// One bin is taken per clock unless stalled; the previous-frame memory is read on
// accept and written back in the cycle after, with forwarding when a one-bin frame
// repeats an entry. A frame's result word is offered once the result queue holds it.
// Reset is synchronous; no clearing pass is needed, since a fill mark makes unwritten
// bins read as zero.
// The input stalls only when the two-word result queue could overflow.
module spectral_flux_beat_detector_unit (
   input  logic                                clock,
   input  logic                                reset,
   sfbd_req_if.sink                            req_if,
   sfbd_rsp_if.source                          rsp_if,
   input  logic                                csr_write_enable,
   input  logic [sfbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfbd_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   logic [sfbd_pkg::THR_W-1:0]  threshold_ff;
   logic [sfbd_pkg::HOLD_W-1:0] holdoff_frames_ff;

   logic                        accept;
   logic                        pending;
   logic                        result_push;
   sfbd_pkg::sfbd_result_type   result;
   logic [1:0]                  count;
   logic [2:0]                  occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sfbd_pkg::THRESHOLD_RESET;
         holdoff_frames_ff <= sfbd_pkg::HOLDOFF_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sfbd_pkg::CSR_FLUX_THRESHOLD: begin
               threshold_ff <= csr_write_data[sfbd_pkg::THR_W-1:0];
            end
            sfbd_pkg::CSR_HOLDOFF_FRAMES: begin
               holdoff_frames_ff <= csr_write_data[sfbd_pkg::HOLD_W-1:0];
            end
            default: begin
               threshold_ff <= threshold_ff;
            end
         endcase
      end
   end

   // Words held after the next edge, counting the frame result now in flight.
   assign occupancy = {1'b0, count} + {2'b00, pending} - {2'b00, rsp_if.valid && rsp_if.ready};
   assign req_if.ready = occupancy <= 3'd1;
   assign accept = req_if.valid && req_if.ready;

   sfbd_flux u_flux (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .magnitude      (req_if.magnitude),
      .last_bin       (req_if.last_bin),
      .flux_threshold (threshold_ff),
      .holdoff_frames (holdoff_frames_ff),
      .pending        (pending),
      .result_push    (result_push),
      .result         (result)
   );

   sfbd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .count     (count),
      .rsp_if    (rsp_if)
   );

endmodule
